// ===== rtl/c8x_pkg.sv =====
// Shared types and constants for the CHIP-8 instruction executor.
package c8x_pkg;

  localparam int AddrW = 12;
  localparam int SpW = 5;
  localparam int StackDepth = 16;

  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_REG   = 2'd3;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_OVERFLOW    = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW   = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  localparam logic [AddrW-1:0] START_RESET = 12'h200;

  // ALU operation codes for the shared arithmetic unit
  typedef enum logic [3:0] {
    ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR, ALU_SUBN,
    ALU_SHL, ALU_EQ
  } alu_op_t;

  typedef struct packed {
    logic [7:0] res;
    logic       flag;
    logic       eq;
  } alu_out_t;

endpackage

// ===== rtl/c8x_alu.sv =====
// Shared 8-bit arithmetic, logic, shift and compare unit.
module c8x_alu (
  input  c8x_pkg::alu_op_t  op,
  input  logic [7:0]        a,
  input  logic [7:0]        b,
  output c8x_pkg::alu_out_t q
);
  import c8x_pkg::*;

  logic [8:0] sum;
  logic [8:0] dab;
  logic [8:0] dba;

  assign sum = {1'b0, a} + {1'b0, b};
  assign dab = {1'b0, a} - {1'b0, b};
  assign dba = {1'b0, b} - {1'b0, a};

  // Pick the result and flag for the requested operation
  always_comb begin
    q.eq = (a == b);
    q.res = b;
    q.flag = 1'b0;
    unique case (op)
      ALU_MOV:  q.res = b;
      ALU_OR:   q.res = a | b;
      ALU_AND:  q.res = a & b;
      ALU_XOR:  q.res = a ^ b;
      ALU_ADD: begin q.res = sum[7:0]; q.flag = sum[8]; end
      ALU_SUB: begin q.res = dab[7:0]; q.flag = ~dab[8]; end
      ALU_SHR: begin q.res = {1'b0, a[7:1]}; q.flag = a[0]; end
      ALU_SUBN: begin q.res = dba[7:0]; q.flag = ~dba[8]; end
      ALU_SHL: begin q.res = {a[6:0], 1'b0}; q.flag = a[7]; end
      ALU_EQ:   q.res = b;
      default:  q.res = b;
    endcase
  end
endmodule

// ===== rtl/chip8_instruction_executor.sv =====
// Top level of the CHIP-8 instruction executor: sequencer, storage and handshakes.
// Each transaction runs under a small sequencer sharing one memory port and one
// 8-bit ALU. Memory write and register read go straight to the done state, memory
// read passes a read state first, and a step fetches two opcode bytes and executes,
// then writes one memory byte each for BCD store (3) and block save (x+1), or reads
// one byte into a register each for block load (x+1, up to 16 bytes). The single-port
// 4 KiB byte memory carries every access. One result register holds the answer
// until taken; the next transaction waits until it is delivered. A configuration
// write only updates the start address register; the program counter keeps its value.
module chip8_instruction_executor (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [11:0] address,
  input  logic [7:0]  write_data,
  input  logic [3:0]  register_select,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_data,
  output logic [11:0] program_counter,
  output logic [11:0] index_value,
  output logic [1:0]  status
);
  import c8x_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_FETCH0, S_FETCH1, S_FETCH2, S_EXEC, S_BCD, S_SAVE,
    S_LOAD_RD, S_LOAD_WR, S_DONE
  } state_t;

  state_t           state;
  logic [7:0]       mem [0:4095];
  logic [11:0]      stk [0:StackDepth-1];
  logic [7:0]       vreg [0:15];
  logic [11:0]      start_addr;
  logic [11:0]      pc;
  logic [11:0]      idx;
  logic [SpW-1:0]   sp;
  logic [7:0]       mem_q;
  logic [11:0]      mem_addr;
  logic             mem_we;
  logic [7:0]       mem_wd;
  logic [15:0]      op;
  logic [3:0]       cnt;
  logic [1:0]       bcd_step;
  logic [7:0]       rdata;
  logic [1:0]       st;
  logic [7:0]       hund;
  logic [7:0]       tens;
  logic [7:0]       ones;
  logic [7:0]       bcd_v;
  logic [7:0]       bcd_rem;
  logic [15:0]      bcd_prod;
  alu_op_t          aop;
  alu_out_t         aq;
  logic [3:0]       ox;
  logic [3:0]       oy;

  assign ox = op[11:8];
  assign oy = op[7:4];

  // Select the ALU operation from the opcode
  always_comb begin
    aop = ALU_EQ;
    if (op[15:12] == 4'h8) begin
      unique case (op[3:0])
        4'h0: aop = ALU_MOV;
        4'h1: aop = ALU_OR;
        4'h2: aop = ALU_AND;
        4'h3: aop = ALU_XOR;
        4'h4: aop = ALU_ADD;
        4'h5: aop = ALU_SUB;
        4'h6: aop = ALU_SHR;
        4'h7: aop = ALU_SUBN;
        4'hE: aop = ALU_SHL;
        default: aop = ALU_EQ;
      endcase
    end else if (op[15:12] == 4'h7) begin
      aop = ALU_ADD;
    end
  end

  c8x_alu u_alu (
    .op (aop),
    .a  (vreg[ox]),
    .b  ((op[15:12] == 4'h7 || op[15:12] == 4'h3 || op[15:12] == 4'h4) ?
         op[7:0] : vreg[oy]),
    .q  (aq)
  );

  // Split Vx into decimal digits: compare for hundreds, reciprocal multiply for tens
  always_comb begin
    bcd_v = vreg[ox];
    hund = (bcd_v >= 8'd200) ? 8'd2 : (bcd_v >= 8'd100) ? 8'd1 : 8'd0;
    bcd_rem = bcd_v - ((bcd_v >= 8'd200) ? 8'd200 : (bcd_v >= 8'd100) ? 8'd100 : 8'd0);
    bcd_prod = {8'd0, bcd_rem} * 16'd205;
    tens = {4'd0, bcd_prod[14:11]};
    ones = bcd_rem - {tens[4:0], 3'b000} - {tens[6:0], 1'b0};
  end

  // Drive the memory port for the current state
  always_comb begin
    mem_we = 1'b0;
    mem_wd = 8'd0;
    mem_addr = address;
    unique case (state)
      S_IDLE: begin
        mem_addr = address;
        mem_we = in_valid && in_ready && command == CMD_WRITE;
        mem_wd = write_data;
      end
      S_FETCH0: mem_addr = pc;
      S_FETCH1: mem_addr = pc + 12'd1;
      S_BCD: begin
        mem_addr = idx + 12'(bcd_step);
        mem_we = 1'b1;
        mem_wd = (bcd_step == 2'd0) ? hund : (bcd_step == 2'd1) ? tens : ones;
      end
      S_SAVE: begin
        mem_addr = idx + 12'(cnt);
        mem_we = 1'b1;
        mem_wd = vreg[cnt];
      end
      S_LOAD_RD: mem_addr = idx + 12'(cnt);
      default: mem_addr = address;
    endcase
  end

  // Hold the byte memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    mem_q <= mem[mem_addr];
  end

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign read_data = rdata;
  assign program_counter = pc;
  assign index_value = idx;
  assign status = st;

  // Sequence one transaction, update architectural state and the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      start_addr <= START_RESET;
      pc <= START_RESET;
      idx <= '0;
      sp <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 16; i++) vreg[i] <= 8'd0;
    end else begin
      if (cfg_valid) begin
        start_addr <= cfg_data;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            rdata <= 8'd0;
            st <= ST_OK;
            unique case (command)
              CMD_STEP:  state <= S_FETCH0;
              CMD_WRITE: state <= S_DONE;
              CMD_READ:  state <= S_RD;
              CMD_REG: begin
                rdata <= vreg[register_select];
                state <= S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_RD: begin
          rdata <= mem_q;
          state <= S_DONE;
        end
        S_FETCH0: state <= S_FETCH1;
        S_FETCH1: begin
          op[15:8] <= mem_q;
          state <= S_FETCH2;
        end
        S_FETCH2: begin
          op[7:0] <= mem_q;
          pc <= pc + 12'd2;
          state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_DONE;
          cnt <= 4'd0;
          bcd_step <= 2'd0;
          unique case (op[15:12])
            4'h0: begin
              if (op != 16'h00EE) st <= ST_UNSUPPORTED;
              else if (sp == '0) st <= ST_UNDERFLOW;
              else begin
                sp <= sp - 1'b1;
                pc <= stk[4'(sp - 1'b1)];
              end
            end
            4'h1: pc <= op[11:0];
            4'h2: begin
              if (sp >= SpW'(StackDepth)) st <= ST_OVERFLOW;
              else begin
                stk[sp[3:0]] <= pc;
                sp <= sp + 1'b1;
                pc <= op[11:0];
              end
            end
            4'h3: if (aq.eq) pc <= pc + 12'd2;
            4'h4: if (!aq.eq) pc <= pc + 12'd2;
            4'h5: begin
              if (op[3:0] != 4'h0) st <= ST_UNSUPPORTED;
              else if (aq.eq) pc <= pc + 12'd2;
            end
            4'h6: vreg[ox] <= op[7:0];
            4'h7: vreg[ox] <= aq.res;
            4'h8: begin
              if (aop == ALU_EQ) st <= ST_UNSUPPORTED;
              else if (aop == ALU_MOV || aop == ALU_OR || aop == ALU_AND ||
                       aop == ALU_XOR) begin
                vreg[ox] <= aq.res;
              end else begin
                // VF is written last, so it keeps the flag when x is F
                if (ox != 4'hF) vreg[ox] <= aq.res;
                vreg[15] <= {7'd0, aq.flag};
              end
            end
            4'h9: begin
              if (op[3:0] != 4'h0) st <= ST_UNSUPPORTED;
              else if (!aq.eq) pc <= pc + 12'd2;
            end
            4'hA: idx <= op[11:0];
            4'hB: pc <= op[11:0] + {4'd0, vreg[0]};
            4'hF: begin
              unique case (op[7:0])
                8'h1E: idx <= idx + {4'd0, vreg[ox]};
                8'h33: state <= S_BCD;
                8'h55: state <= S_SAVE;
                8'h65: state <= S_LOAD_RD;
                default: st <= ST_UNSUPPORTED;
              endcase
            end
            default: st <= ST_UNSUPPORTED;
          endcase
        end
        S_BCD: begin
          bcd_step <= bcd_step + 2'd1;
          if (bcd_step == 2'd2) state <= S_DONE;
        end
        S_SAVE: begin
          cnt <= cnt + 4'd1;
          if (cnt == ox) state <= S_DONE;
        end
        S_LOAD_RD: state <= S_LOAD_WR;
        S_LOAD_WR: begin
          vreg[cnt] <= mem_q;
          cnt <= cnt + 4'd1;
          state <= (cnt == ox) ? S_DONE : S_LOAD_RD;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
